>>> rtl/double_ended_queue_defines.svh
// Assertion macros used by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, held off during reset.
`define DEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

>>> rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_REAR  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_PEEK       = 3'd4
    } deq_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } deq_status_t;

    // Broadcast command to every cell; at most one bit is set
    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic push_rear;
        logic pop_rear;
    } deq_op_t;

endpackage

>>> rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue built from a chain of cells.
//   Input channel (in_valid/in_ready, mode, push_value): one transaction per
//   operation - push front, push rear, pop front, pop rear or peek (codes 5 to
//   7 act as peek). Output channel (out_valid/out_ready): one transaction per
//   operation with the front and rear entries afterwards (all ones when empty),
//   the entry count, empty and full flags and a status (ok, overflow,
//   underflow).
//   Storage is a row of CAPACITY cells; cell 0 always holds the front entry and
//   the valid cells form a contiguous run from it. Push front shifts the whole
//   row right, pop front shifts it left, push rear fills the first free cell and
//   pop rear drops the last valid cell - every cell moves in the same cycle.
//   The result is registered and appears in the cycle after the input transaction.
//   Throughput: one operation per cycle while the receiver keeps out_ready
//   high; the single result register sets this figure.
//   Stall: while a result waits with out_ready low, in_ready is low, the row
//   holds still and the result stays unchanged.
//   Reset: clears every valid flag, the count and the result valid; the queue
//   comes up empty and ready. Entry data is not cleared.
//   Push while full is dropped (overflow); pop while empty is ignored
//   (underflow).
module double_ended_queue #(
    parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [deq_pkg::MODE_W-1:0]   mode,
    input  logic signed [DATA_WIDTH-1:0] push_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] front_value,
    output logic signed [DATA_WIDTH-1:0] rear_value,
    output logic [CNT_W-1:0]             entry_total,
    output logic                         is_empty,
    output logic                         is_full,
    output logic [deq_pkg::STATUS_W-1:0] status
);
    import deq_pkg::*;

    logic                   accept;
    deq_op_t                op;
    deq_status_t            status_next;
    deq_status_t            status_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   full_now;
    logic                   empty_now;

    logic                   cell_valid [CAPACITY];
    logic [DATA_WIDTH-1:0]  cell_data  [CAPACITY];
    logic [DATA_WIDTH-1:0]  rear_pick;

    // Advance only when the result register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full_now  = (count_reg == CNT_W'(CAPACITY));
    assign empty_now = (count_reg == '0);

    // Decode the operation into a cell command, count update and status
    always_comb
    begin
        op          = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        if (accept)
        begin
            unique case (deq_mode_t'(mode))
                MODE_PUSH_FRONT:
                begin
                    if (full_now)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        op.shift_right = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                MODE_PUSH_REAR:
                begin
                    if (full_now)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        op.push_rear = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (empty_now)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        op.shift_left = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                MODE_POP_REAR:
                begin
                    if (empty_now)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        op.pop_rear = 1'b1;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    // peek and unused codes leave the row alone
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (accept)
            begin
                status_reg <= status_next;
            end
        end
    end

    // Row of cells; cell 0 sees the incoming word on its left, the last
    // cell sees an empty neighbour on its right
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                  lv;
        logic [DATA_WIDTH-1:0] ld;
        logic                  rv;
        logic [DATA_WIDTH-1:0] rd;

        if (i == 0)
        begin : g_left_edge
            assign lv = 1'b1;
            assign ld = push_value;
        end
        else
        begin : g_left_inner
            assign lv = cell_valid[i-1];
            assign ld = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_right_edge
            assign rv = 1'b0;
            assign rd = cell_data[i];
        end
        else
        begin : g_right_inner
            assign rv = cell_valid[i+1];
            assign rd = cell_data[i+1];
        end

        deq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .push_value  (push_value),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .valid       (cell_valid[i]),
            .data        (cell_data[i])
        );
    end

    // Rear entry: the one valid cell whose right neighbour is empty
    always_comb
    begin
        rear_pick = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_valid[i] && ((i == CAPACITY - 1) || !cell_valid[(i + 1) % CAPACITY]))
            begin
                rear_pick = rear_pick | cell_data[i];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign front_value = empty_now ? '1 : cell_data[0];
    assign rear_value  = empty_now ? '1 : rear_pick;
    assign entry_total = count_reg;
    assign is_empty    = empty_now;
    assign is_full     = full_now;
    assign status      = status_reg;

endmodule

>>> rtl/deq_cell.sv
// One storage cell of the queue chain: holds one entry and its valid flag.
module deq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  deq_pkg::deq_op_t       op,
    input  logic [DATA_WIDTH-1:0]  push_value,
    input  logic                   left_valid,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic                   right_valid,
    input  logic [DATA_WIDTH-1:0]  right_data,
    output logic                   valid,
    output logic [DATA_WIDTH-1:0]  data
);
    import deq_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (op.shift_right)
        begin
            valid_next = left_valid;
            data_next  = left_data;
        end
        else if (op.shift_left)
        begin
            valid_next = right_valid;
            data_next  = right_data;
        end
        else if (op.push_rear && !valid_reg && left_valid)
        begin
            // first free cell takes the new rear entry
            valid_next = 1'b1;
            data_next  = push_value;
        end
        else if (op.pop_rear && valid_reg && !right_valid)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> rtl/deq_checker.sv
// Port-level checker for the double-ended queue and its bind.
`include "double_ended_queue_defines.svh"

module deq_checker #(
    parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [DATA_WIDTH-1:0]        front_value,
    input logic [DATA_WIDTH-1:0]        rear_value,
    input logic [CNT_W-1:0]             entry_total,
    input logic                         is_empty,
    input logic                         is_full,
    input logic [deq_pkg::STATUS_W-1:0] status
);
    import deq_pkg::*;

    // Empty result shows all-ones entries and a zero count
    `DEQ_ASSERT_IMP(a_empty_view, clk, rst_n, out_valid && is_empty,
        entry_total == '0 && front_value == '1 && rear_value == '1)

    // Full flag agrees with the count
    `DEQ_ASSERT_IMP(a_full_count, clk, rst_n, out_valid,
        is_full == (entry_total == CNT_W'(CAPACITY)))

    // A dropped push can only happen on a full queue, an ignored pop on an empty one
    `DEQ_ASSERT_IMP(a_status_flags, clk, rst_n, out_valid,
        (status != ST_OVERFLOW || is_full) && (status != ST_UNDERFLOW || is_empty))

    // Stalled result holds
    `DEQ_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(front_value) && $stable(rear_value) &&
        $stable(entry_total) && $stable(status))

    // Every input transaction leaves a result waiting in the next cycle
    `DEQ_ASSERT_NXT(a_accept_result, clk, rst_n, in_valid && in_ready, out_valid)

endmodule

bind double_ended_queue deq_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
) u_deq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .front_value (front_value),
    .rear_value  (rear_value),
    .entry_total (entry_total),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .status      (status)
);
